/* rtl/rpfa_pkg.sv */
// ----------------------------------------------------------------------------
// rpfa_pkg
// Shared types and codes of the reference-counted page frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package rpfa_pkg;

    // Field widths of the request and response
    localparam int MODE_W   = 3;
    localparam int FRAME_W  = 16;
    localparam int STATUS_W = 2;
    localparam int REF_W    = 8;
    localparam int FREE_W   = 17;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRAME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 1'd1;
    localparam int CFG_DATA_W = 17;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ALLOC    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FREE     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ADD_REF  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DROP_REF = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DONATE   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [FRAME_W-1:0] frame;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame_out;
        logic [REF_W-1:0]    ref_count;
        logic [FREE_W-1:0]   free_frames;
    } rsp_t;

    // Free stack commands, issued at commit
    typedef struct packed {
        logic push;
        logic pop;
    } stk_cmd_t;

endpackage

`default_nettype wire

/* rtl/refcounted_page_frame_allocator_top.sv */
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator_top
// Page frame allocator with per-frame reference counts: request decode,
// configuration registers and the read-modify-write sequencer.
// ----------------------------------------------------------------------------
// Sequence: the count or stack top is read at the accepting edge; modify and
//   write-back happen at commit in ST_EXEC, where rsp_valid is registered.
// A new request is taken only in ST_IDLE, as each one reads and then writes the
//   reference count memory; a waiting response holds commit, so one more request
//   is taken and then req_ready stays low until the response is accepted.
// Reset: all control clears at once, then a clearing pass zeroes the reference
//   counts; req_ready stays low until it ends.
`default_nettype none

module refcounted_page_frame_allocator_top #(
    parameter int NUM_FRAMES = 65536,
    parameter int COUNT_BITS = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_ready,
    input  wire rpfa_pkg::req_t                     req,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_ready,
    output rpfa_pkg::rsp_t                          rsp,
    input  wire logic                               cfg_wen,
    input  wire logic [rpfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rpfa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IDX_W   = $clog2(NUM_FRAMES);
    localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
    localparam int FRAME_W = rpfa_pkg::FRAME_W;
    localparam int REF_W   = rpfa_pkg::REF_W;
    localparam int FREE_W  = rpfa_pkg::FREE_W;
    localparam logic [31:0]           NUM_FRAMES_U = 32'(NUM_FRAMES);
    localparam logic [CNT_W-1:0]      FULL_COUNT   = CNT_W'(NUM_FRAMES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE    = COUNT_BITS'(1);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Configuration registers
    logic [FRAME_W-1:0] first_frame_reg;
    logic [FRAME_W:0]   frame_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_frame_reg <= '0;
            frame_limit_reg <= 17'h10000;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                rpfa_pkg::CFG_FIRST_FRAME: first_frame_reg <= cfg_data[FRAME_W-1:0];
                rpfa_pkg::CFG_FRAME_LIMIT: frame_limit_reg <= cfg_data[FRAME_W:0];
                default: ;
            endcase
        end
    end

    // State and registered outputs
    state_t                          state_reg,  state_next;
    logic [rpfa_pkg::MODE_W-1:0]     mode_reg,   mode_next;
    logic [FRAME_W-1:0]              frame_reg,  frame_next;
    logic                            range_reg,  range_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    rpfa_pkg::rsp_t                  rsp_reg,    rsp_next;

    // Memory interfaces
    logic                    rc_rd_en;
    logic [IDX_W-1:0]        rc_rd_idx;
    logic [COUNT_BITS-1:0]   rc_rd_data;
    logic                    rc_wr_en;
    logic [IDX_W-1:0]        rc_wr_idx;
    logic [COUNT_BITS-1:0]   rc_wr_data;
    logic                    rc_clearing;
    logic                    st_rd_top;
    rpfa_pkg::stk_cmd_t      st_cmd;
    logic [FRAME_W-1:0]      st_top;
    logic [CNT_W-1:0]        st_count;

    // Datapath temporaries
    logic                    accept;
    logic                    req_in_range;
    logic                    commit;
    logic                    st_empty;
    logic                    st_full;
    logic [COUNT_BITS-1:0]   cnt_dec;
    logic [COUNT_BITS-1:0]   cnt_inc;
    logic [COUNT_BITS-1:0]   cnt_res;
    logic [CNT_W-1:0]        free_after;

    rpfa_refcnt #(
        .DEPTH  (NUM_FRAMES),
        .DATA_W (COUNT_BITS)
    ) u_refcnt (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rc_rd_en),
        .rd_idx   (rc_rd_idx),
        .rd_data  (rc_rd_data),
        .wr_en    (rc_wr_en),
        .wr_idx   (rc_wr_idx),
        .wr_data  (rc_wr_data),
        .clearing (rc_clearing)
    );

    rpfa_stack #(
        .DEPTH (NUM_FRAMES)
    ) u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_top     (st_rd_top),
        .cmd        (st_cmd),
        .push_frame (frame_reg),
        .top_frame  (st_top),
        .count      (st_count)
    );

    // Request decode and memory reads in the accept cycle
    assign req_ready = (state_reg == ST_IDLE) && !rc_clearing;
    assign accept    = req_valid && req_ready;
    assign req_in_range = (req.frame >= first_frame_reg)
                       && ({1'b0, req.frame} < frame_limit_reg)
                       && (32'(req.frame) < NUM_FRAMES_U);
    assign st_empty  = (st_count == '0);
    assign st_full   = (st_count == FULL_COUNT);
    assign rc_rd_en  = accept && (req.mode != rpfa_pkg::MODE_ALLOC) && req_in_range;
    assign rc_rd_idx = IDX_W'(req.frame);
    assign st_rd_top = accept && (req.mode == rpfa_pkg::MODE_ALLOC) && !st_empty;

    // Saturating count updates
    assign cnt_dec = (rc_rd_data == '0) ? '0 : rc_rd_data - 1'b1;
    assign cnt_inc = (rc_rd_data == COUNT_MAX) ? COUNT_MAX : rc_rd_data + 1'b1;

    // Commit needs the response slot free
    assign commit = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);

    // Modify, write-back and response
    always_comb
    begin
        rsp_next        = rsp_reg;
        rsp_next.status = rpfa_pkg::STATUS_OK;
        rsp_next.frame_out = frame_reg;
        cnt_res         = '0;
        rc_wr_en        = 1'b0;
        rc_wr_idx       = IDX_W'(frame_reg);
        rc_wr_data      = rc_rd_data;
        st_cmd.push     = 1'b0;
        st_cmd.pop      = 1'b0;

        if (mode_reg == rpfa_pkg::MODE_ALLOC)
        begin
            if (st_empty)
            begin
                rsp_next.status    = rpfa_pkg::STATUS_EMPTY;
                rsp_next.frame_out = '0;
            end
            else
            begin
                st_cmd.pop         = commit;
                rsp_next.frame_out = st_top;
                rc_wr_en           = commit;
                rc_wr_idx          = IDX_W'(st_top);
                rc_wr_data         = COUNT_ONE;
                cnt_res            = COUNT_ONE;
            end
        end
        else if (!range_reg)
        begin
            rsp_next.status = rpfa_pkg::STATUS_RANGE;
        end
        else
        begin
            cnt_res = rc_rd_data;
            case (mode_reg)
                rpfa_pkg::MODE_FREE:
                begin
                    rc_wr_en   = commit;
                    rc_wr_data = cnt_dec;
                    cnt_res    = cnt_dec;
                    if (cnt_dec == '0)
                    begin
                        if (st_full)
                        begin
                            rsp_next.status = rpfa_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            st_cmd.push = commit;
                        end
                    end
                end
                rpfa_pkg::MODE_ADD_REF:
                begin
                    rc_wr_en   = commit;
                    rc_wr_data = cnt_inc;
                    cnt_res    = cnt_inc;
                end
                rpfa_pkg::MODE_DROP_REF:
                begin
                    rc_wr_en   = commit;
                    rc_wr_data = cnt_dec;
                    cnt_res    = cnt_dec;
                end
                rpfa_pkg::MODE_DONATE:
                begin
                    if (st_full)
                    begin
                        rsp_next.status = rpfa_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        rc_wr_en    = commit;
                        rc_wr_data  = '0;
                        cnt_res     = '0;
                        st_cmd.push = commit;
                    end
                end
                // query, and the unused codes behave as query
                default: ;
            endcase
        end

        // Free count as it stands after this operation
        if (mode_reg == rpfa_pkg::MODE_ALLOC && !st_empty)
        begin
            free_after = st_count - 1'b1;
        end
        else if (st_cmd.push || (range_reg && !st_full
                 && ((mode_reg == rpfa_pkg::MODE_DONATE)
                  || (mode_reg == rpfa_pkg::MODE_FREE && cnt_dec == '0))))
        begin
            free_after = st_count + 1'b1;
        end
        else
        begin
            free_after = st_count;
        end

        rsp_next.ref_count   = REF_W'(cnt_res);
        rsp_next.free_frames = FREE_W'(free_after);
    end

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        frame_next     = frame_reg;
        range_next     = range_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = req.mode;
                    frame_next = req.frame;
                    range_next = req_in_range;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= '0;
            frame_reg     <= '0;
            range_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            frame_reg     <= frame_next;
            range_reg     <= range_next;
            rsp_valid_reg <= rsp_valid_next;
            if (commit)
            begin
                rsp_reg <= rsp_next;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        rc_clearing |-> !req_ready)
        else $error("request taken during clearing pass");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_EXEC)
        else $error("accepted request did not start execution");

    a_push_pop_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(st_cmd.push && st_cmd.pop))
        else $error("push and pop in the same cycle");

    a_range_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == rpfa_pkg::STATUS_RANGE) |-> rsp.ref_count == '0)
        else $error("out-of-range response carries a count");
`endif

endmodule

`default_nettype wire

/* rtl/rpfa_refcnt.sv */
// ----------------------------------------------------------------------------
// rpfa_refcnt
// Per-frame reference count memory: one read port with registered data, one
// write port, and a clearing sweep after reset that zeroes every entry.
// ----------------------------------------------------------------------------
`default_nettype none

module rpfa_refcnt #(
    parameter int DEPTH  = 65536,
    parameter int DATA_W = 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_idx,
    output logic      [DATA_W-1:0]        rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_idx,
    input  wire logic [DATA_W-1:0]        wr_data,
    output logic                          clearing
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  clr_idx_reg;
    logic              clearing_reg;

    // Clearing sweep, one entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == LAST_IDX)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Storage: sweep has the write port while it runs
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

`default_nettype wire

/* rtl/rpfa_stack.sv */
// ----------------------------------------------------------------------------
// rpfa_stack
// Free frame stack: memory of frame numbers plus the fill count. The top
// entry is read ahead into a register; push and pop take effect at commit.
// ----------------------------------------------------------------------------
`default_nettype none

module rpfa_stack #(
    parameter int DEPTH = 65536
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                rd_top,
    input  wire rpfa_pkg::stk_cmd_t                  cmd,
    input  wire logic [rpfa_pkg::FRAME_W-1:0]        push_frame,
    output logic      [rpfa_pkg::FRAME_W-1:0]        top_frame,
    output logic      [$clog2(DEPTH+1)-1:0]          count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic [rpfa_pkg::FRAME_W-1:0] mem [DEPTH];
    logic [rpfa_pkg::FRAME_W-1:0] top_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_dec;

    assign count_dec = count_reg - 1'b1;

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.push)
        begin
            count_reg <= count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            count_reg <= count_dec;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[count_reg[IDX_W-1:0]] <= push_frame;
        end
        if (rd_top)
        begin
            top_reg <= mem[count_dec[IDX_W-1:0]];
        end
    end

    assign top_frame = top_reg;
    assign count     = count_reg;

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> count_reg != '0)
        else $error("pop from empty free stack");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> count_reg != DEPTH_C)
        else $error("push onto full free stack");

    a_no_top_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rd_top |-> count_reg != '0)
        else $error("top read of empty free stack");
`endif

endmodule

`default_nettype wire
